// ----- rtl/core/rgbyuv_pkg.sv -----
// Package for the RGB pair to YUYV converter: shared types, fixed-point
// coefficients and the floor-and-saturate helper.
// No dependencies.
package rgbyuv_pkg;

    // Width of every accumulator; covers the luma sum with bias and the
    // chroma pair sum with bias, signed
    localparam int unsigned ACC_W = 26;
    localparam int unsigned PIX_W = 8;

    // BT.601 video-range coefficients, Q.16
    localparam logic signed [ACC_W-1:0] Y_R_COEF = 26'sd16843;
    localparam logic signed [ACC_W-1:0] Y_G_COEF = 26'sd33030;
    localparam logic signed [ACC_W-1:0] Y_B_COEF = 26'sd6423;
    localparam logic signed [ACC_W-1:0] U_R_COEF = -26'sd9699;
    localparam logic signed [ACC_W-1:0] U_G_COEF = -26'sd19071;
    localparam logic signed [ACC_W-1:0] U_B_COEF = 26'sd28770;
    localparam logic signed [ACC_W-1:0] V_R_COEF = 26'sd28770;
    localparam logic signed [ACC_W-1:0] V_G_COEF = -26'sd24117;
    localparam logic signed [ACC_W-1:0] V_B_COEF = -26'sd4653;

    // Biases: 16 in Q.16 for luma, 128 in Q.17 for the chroma pair sum
    localparam logic signed [ACC_W-1:0] Y_BIAS  = 26'sd1048576;
    localparam logic signed [ACC_W-1:0] UV_BIAS = 26'sd16777216;

    // Fractional bits dropped by the final floor
    localparam logic [4:0] Y_FRAC  = 5'd16;
    localparam logic [4:0] UV_FRAC = 5'd17;

    // Per-pixel sums produced by one lane
    typedef struct packed {
        logic signed [ACC_W-1:0] y_acc;   // luma, bias included
        logic signed [ACC_W-1:0] u_dot;   // U dot product, no bias
        logic signed [ACC_W-1:0] v_dot;   // V dot product, no bias
    } lane_sum_t;

    // Floor a fixed-point value and saturate to 0..255
    function automatic logic [PIX_W-1:0] sat_u8(input logic signed [ACC_W-1:0] acc,
                                                input logic [4:0] frac);
        logic signed [ACC_W-1:0] flo;
        logic [PIX_W-1:0]        res;
        flo = acc >>> frac;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (|flo[ACC_W-1:PIX_W]) begin
            res = '1;
        end else begin
            res = flo[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/rgbyuv_lane.sv -----
// One pixel lane: luma and chroma dot products of a single RGB pixel,
// registered. Depends on rgbyuv_pkg.
module rgbyuv_lane (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    output rgbyuv_pkg::lane_sum_t        sum_q
);
    import rgbyuv_pkg::*;

    logic signed [ACC_W-1:0] red_s;
    logic signed [ACC_W-1:0] green_s;
    logic signed [ACC_W-1:0] blue_s;
    lane_sum_t               sum_next;
    lane_sum_t               sum_reg;

    // Zero-extend components into the signed accumulator width
    assign red_s   = $signed({{(ACC_W-PIX_W){1'b0}}, red});
    assign green_s = $signed({{(ACC_W-PIX_W){1'b0}}, green});
    assign blue_s  = $signed({{(ACC_W-PIX_W){1'b0}}, blue});

    // Constant-coefficient dot products
    always_comb begin
        sum_next.y_acc = Y_R_COEF * red_s + Y_G_COEF * green_s + Y_B_COEF * blue_s + Y_BIAS;
        sum_next.u_dot = U_R_COEF * red_s + U_G_COEF * green_s + U_B_COEF * blue_s;
        sum_next.v_dot = V_R_COEF * red_s + V_G_COEF * green_s + V_B_COEF * blue_s;
    end

    // Payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_q = sum_reg;

endmodule

// ----- rtl/core/rgbyuv_merge.sv -----
// Merge stage: averages the two lanes' chroma, floors and saturates all four
// outputs into the registered YUYV word. Depends on rgbyuv_pkg.
module rgbyuv_merge (
    input  logic                  aclk,
    input  logic                  load,
    input  rgbyuv_pkg::lane_sum_t lane_a,
    input  rgbyuv_pkg::lane_sum_t lane_b,
    output logic [31:0]           yuyv_q   // Y0, U, Y1, V from bit 0 up
);
    import rgbyuv_pkg::*;

    logic signed [ACC_W-1:0] u_acc;
    logic signed [ACC_W-1:0] v_acc;
    logic [31:0]             yuyv_next;
    logic [31:0]             yuyv_reg;

    // Pair sums in Q.17 with the 128 offset
    assign u_acc = lane_a.u_dot + lane_b.u_dot + UV_BIAS;
    assign v_acc = lane_a.v_dot + lane_b.v_dot + UV_BIAS;

    // Floor, saturate and pack
    assign yuyv_next = {sat_u8(v_acc, UV_FRAC),
                        sat_u8(lane_b.y_acc, Y_FRAC),
                        sat_u8(u_acc, UV_FRAC),
                        sat_u8(lane_a.y_acc, Y_FRAC)};

    always_ff @(posedge aclk) begin
        if (load) begin
            yuyv_reg <= yuyv_next;
        end
    end

    assign yuyv_q = yuyv_reg;

endmodule

// ----- rtl/core/rgb_pair_to_yuyv_top.sv -----
// Top level of the RGB pair to YUYV 4:2:2 converter: two pixel lanes and a
// merge stage. Depends on rgbyuv_pkg, rgbyuv_lane and rgbyuv_merge.
//
//   channel | dir | tdata                            | tuser
//   s_      | in  | B0 G0 R0 B1 G1 R1 (48 bits)      | second_present
//   m_      | out | Y0 U Y1 V (32 bits)              | -
//
// One item per clock sustained while m_tready stays high; an accepted item
// passes the lane register, then the merge register. Throughput is set by the
// two-stage pipeline, each stage moving whenever its successor is empty or being drained.
// Reset clears both stage valid flags; payload is not reset.
// A stall on m_ fills the pipeline, after which s_tready drops.
module rgb_pair_to_yuyv_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // blue_first, green_first, red_first,
                                   // blue_second, green_second, red_second
    input  logic        s_tuser,   // second_present
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // luma_first, chroma_blue, luma_second, chroma_red
);
    import rgbyuv_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_ready;
    logic       s1_load;
    logic       out_load;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    lane_sum_t  sum_a;
    lane_sum_t  sum_b;

    // Pipeline handshake
    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s1_load   = s_tvalid && s_tready;
    assign out_load  = s1_valid_reg && out_ready;

    always_comb begin
        s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;
        m_valid_next  = out_ready ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Odd row end: second lane repeats the first pixel
    assign blue_b  = s_tuser ? s_tdata[31:24] : s_tdata[7:0];
    assign green_b = s_tuser ? s_tdata[39:32] : s_tdata[15:8];
    assign red_b   = s_tuser ? s_tdata[47:40] : s_tdata[23:16];

    rgbyuv_lane u_lane_a (
        .aclk  (aclk),
        .load  (s1_load),
        .red   (s_tdata[23:16]),
        .green (s_tdata[15:8]),
        .blue  (s_tdata[7:0]),
        .sum_q (sum_a)
    );

    rgbyuv_lane u_lane_b (
        .aclk  (aclk),
        .load  (s1_load),
        .red   (red_b),
        .green (green_b),
        .blue  (blue_b),
        .sum_q (sum_b)
    );

    rgbyuv_merge u_merge (
        .aclk   (aclk),
        .load   (out_load),
        .lane_a (sum_a),
        .lane_b (sum_b),
        .yuyv_q (m_tdata)
    );

    assign m_tvalid = m_valid_reg;

    // Back-pressure only when both stages hold an item
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg))
        else $error("s_tready low with an empty stage");

    // An accepted item occupies the lane stage next cycle
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted item lost from lane stage");

    // Output valid only appears from an occupied lane stage
    a_out_from_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("result produced without a lane item");

endmodule
